@@ src/jsig_pkg.sv @@
// ----------------------------------------------------------------------------
// jsig_pkg
// Shared types and constants for the job-shop instance generator: stream
// constants, limits, the sequencer states and the interface structs.
// ----------------------------------------------------------------------------
package jsig_pkg;

  localparam int unsigned MaxJobs     = 128;
  localparam int unsigned MaxMachines = 32;

  localparam int unsigned SeedW = 31;
  localparam int unsigned MulBW = 15;
  localparam int unsigned ProdW = SeedW + MulBW;
  localparam int unsigned JobW  = 8;
  localparam int unsigned McntW = 6;
  localparam int unsigned DurW  = 8;
  localparam int unsigned RowAw = $clog2(MaxMachines);
  localparam int unsigned CfgIw = 3;

  localparam logic [MulBW-1:0] LcgMul = MulBW'(16807);
  localparam logic [SeedW-1:0] LcgMod = SeedW'(2147483647);

  localparam logic [SeedW-1:0] TimeSeedRst = SeedW'(840612802);
  localparam logic [SeedW-1:0] MachSeedRst = SeedW'(398197754);
  localparam logic [JobW-1:0]  JobCntRst   = JobW'(15);
  localparam logic [McntW-1:0] MachCntRst  = McntW'(15);
  localparam logic [DurW-1:0]  DurMinRst   = DurW'(1);
  localparam logic [DurW-1:0]  DurMaxRst   = DurW'(99);

  typedef enum logic [CfgIw-1:0] {
    CFG_TIME_SEED = 3'd0,
    CFG_MACH_SEED = 3'd1,
    CFG_JOB_CNT   = 3'd2,
    CFG_MACH_CNT  = 3'd3,
    CFG_DUR_MIN   = 3'd4,
    CFG_DUR_MAX   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_TM,
    ST_TF,
    ST_MF,
    ST_TQ,
    ST_MQ,
    ST_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [SeedW-1:0] dur_seed;
    logic [SeedW-1:0] mach_seed;
    logic [JobW-1:0]  job_cnt;
    logic [McntW-1:0] mach_cnt;
    logic [DurW-1:0]  dur_min;
    logic [DurW-1:0]  dur_max;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [SeedW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [SeedW-1:0] residue;
    logic [DurW-1:0]  quotient;
  } fold_t;

endpackage

@@ src/jsig_arith.sv @@
// ----------------------------------------------------------------------------
// jsig_arith
// Shared arithmetic unit: one registered 31x15 multiplier followed by a
// Mersenne fold that yields both the residue mod 2^31-1 and the quotient.
// ----------------------------------------------------------------------------
module jsig_arith (
  input  logic                clk_i,
  input  jsig_pkg::mul_req_t  req_i,
  output jsig_pkg::fold_t     fold_o
);

  logic [jsig_pkg::ProdW-1:0] prod_q;
  logic [jsig_pkg::MulBW-1:0] hi;
  logic [jsig_pkg::SeedW-1:0] lo;
  logic [jsig_pkg::SeedW:0]   sum;
  logic [jsig_pkg::SeedW:0]   sub;
  logic                       ge;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= jsig_pkg::ProdW'(req_i.a) * jsig_pkg::ProdW'(req_i.b);
    end
  end

  // p = hi*2^31 + lo, so p mod (2^31-1) and p div (2^31-1) follow from hi + lo
  assign hi  = prod_q[jsig_pkg::ProdW-1:jsig_pkg::SeedW];
  assign lo  = prod_q[jsig_pkg::SeedW-1:0];
  assign sum = {1'b0, lo} + (jsig_pkg::SeedW+1)'(hi);
  assign ge  = (sum >= {1'b0, jsig_pkg::LcgMod});
  assign sub = sum - {1'b0, jsig_pkg::LcgMod};

  assign fold_o.residue  = ge ? sub[jsig_pkg::SeedW-1:0] : sum[jsig_pkg::SeedW-1:0];
  assign fold_o.quotient = hi[jsig_pkg::DurW-1:0] + jsig_pkg::DurW'(ge);

endmodule

@@ src/jsig_ctrl.sv @@
// ----------------------------------------------------------------------------
// jsig_ctrl
// Sequencer: holds both streams, the job counter and the machine row, drives
// the shared arithmetic unit and emits one word per operation, or an exhausted word.
// ----------------------------------------------------------------------------
module jsig_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jsig_pkg::cfg_t                cfg_i,
  input  logic                          start_i,
  input  logic                          restart_i,
  output logic                          busy_o,
  output jsig_pkg::mul_req_t            mul_req_o,
  input  jsig_pkg::fold_t               fold_i,
  output logic                          result_valid_o,
  output logic [6:0]                    job_index_o,
  output logic [4:0]                    op_index_o,
  output logic [jsig_pkg::DurW-1:0]     duration_o,
  output logic [4:0]                    machine_o,
  output logic                          last_op_o,
  output logic                          last_job_o,
  output logic                          exhausted_o
);

  jsig_pkg::state_e state_q, state_d;

  logic [jsig_pkg::SeedW-1:0] time_q, mach_q;
  logic [jsig_pkg::JobW-1:0]  next_job_q;
  logic [jsig_pkg::RowAw-1:0] op_q, k_q;
  logic [jsig_pkg::DurW-1:0]  dur_q;
  logic [jsig_pkg::RowAw-1:0] rd_i_q, rd_k_q;
  logic [jsig_pkg::RowAw-1:0] row_mem [jsig_pkg::MaxMachines];

  logic                       valid_q, valid_d;
  logic [6:0]                 job_o_q;
  logic [4:0]                 op_o_q;
  logic [jsig_pkg::DurW-1:0]  dur_o_q;
  logic [4:0]                 mach_o_q;
  logic                       last_op_q, last_job_q, exh_q;

  logic [jsig_pkg::JobW-1:0]  n_eff;
  logic [jsig_pkg::McntW-1:0] m_eff;
  logic [jsig_pkg::DurW:0]    span;
  logic [jsig_pkg::McntW-1:0] m_left;
  logic                       op_last, exh_now, accept;

  logic                       mem_we, mem_re;
  logic [jsig_pkg::RowAw-1:0] mem_wa, mem_wd;

  // effective configuration
  always_comb begin
    if (cfg_i.job_cnt == '0) begin
      n_eff = jsig_pkg::JobW'(1);
    end else if (cfg_i.job_cnt > jsig_pkg::JobW'(jsig_pkg::MaxJobs)) begin
      n_eff = jsig_pkg::JobW'(jsig_pkg::MaxJobs);
    end else begin
      n_eff = cfg_i.job_cnt;
    end
    if (cfg_i.mach_cnt == '0) begin
      m_eff = jsig_pkg::McntW'(1);
    end else if (cfg_i.mach_cnt > jsig_pkg::McntW'(jsig_pkg::MaxMachines)) begin
      m_eff = jsig_pkg::McntW'(jsig_pkg::MaxMachines);
    end else begin
      m_eff = cfg_i.mach_cnt;
    end
    span = (cfg_i.dur_max >= cfg_i.dur_min) ?
           ({1'b0, cfg_i.dur_max} - {1'b0, cfg_i.dur_min} + (jsig_pkg::DurW+1)'(1)) :
           (jsig_pkg::DurW+1)'(1);
  end

  assign m_left  = m_eff - jsig_pkg::McntW'(op_q);
  assign op_last = (jsig_pkg::McntW'(op_q) == (m_eff - jsig_pkg::McntW'(1)));
  assign busy_o  = (state_q != jsig_pkg::ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign exh_now = !restart_i && (next_job_q >= n_eff);
  assign valid_d = (state_q == jsig_pkg::ST_EMIT) || (accept && exh_now);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jsig_pkg::ST_IDLE: begin
        if (start_i && !exh_now) begin
          state_d = jsig_pkg::ST_INIT;
        end
      end
      jsig_pkg::ST_INIT: begin
        if (op_last) begin
          state_d = jsig_pkg::ST_TM;
        end
      end
      jsig_pkg::ST_TM:   state_d = jsig_pkg::ST_TF;
      jsig_pkg::ST_TF:   state_d = jsig_pkg::ST_MF;
      jsig_pkg::ST_MF:   state_d = jsig_pkg::ST_TQ;
      jsig_pkg::ST_TQ:   state_d = jsig_pkg::ST_MQ;
      jsig_pkg::ST_MQ:   state_d = jsig_pkg::ST_RD;
      jsig_pkg::ST_RD:   state_d = jsig_pkg::ST_EMIT;
      jsig_pkg::ST_EMIT: begin
        state_d = op_last ? jsig_pkg::ST_IDLE : jsig_pkg::ST_TM;
      end
      default:           state_d = jsig_pkg::ST_IDLE;
    endcase
  end

  // unit and memory controls
  always_comb begin
    mul_req_o = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = op_q;
    mem_wd    = op_q;
    unique case (state_q)
      jsig_pkg::ST_INIT: begin
        mem_we = 1'b1;
      end
      jsig_pkg::ST_TM: begin
        mul_req_o = '{en: 1'b1, a: time_q, b: jsig_pkg::LcgMul};
      end
      jsig_pkg::ST_TF: begin
        mul_req_o = '{en: 1'b1, a: mach_q, b: jsig_pkg::LcgMul};
      end
      jsig_pkg::ST_MF: begin
        mul_req_o = '{en: 1'b1, a: time_q, b: jsig_pkg::MulBW'(span)};
      end
      jsig_pkg::ST_TQ: begin
        mul_req_o = '{en: 1'b1, a: mach_q, b: jsig_pkg::MulBW'(m_left)};
      end
      jsig_pkg::ST_RD: begin
        mem_re = 1'b1;
      end
      jsig_pkg::ST_EMIT: begin
        mem_we = 1'b1;
        mem_wa = k_q;
        mem_wd = rd_i_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_i_q <= row_mem[op_q];
      rd_k_q <= row_mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= jsig_pkg::ST_IDLE;
      time_q     <= jsig_pkg::TimeSeedRst;
      mach_q     <= jsig_pkg::MachSeedRst;
      next_job_q <= '0;
      op_q       <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      unique case (state_q)
        jsig_pkg::ST_IDLE: begin
          op_q <= '0;
          if (start_i) begin
            if (restart_i) begin
              time_q     <= cfg_i.dur_seed;
              mach_q     <= cfg_i.mach_seed;
              next_job_q <= '0;
            end
          end
        end
        jsig_pkg::ST_INIT: begin
          op_q <= op_last ? '0 : op_q + jsig_pkg::RowAw'(1);
        end
        jsig_pkg::ST_TF: time_q <= fold_i.residue;
        jsig_pkg::ST_MF: mach_q <= fold_i.residue;
        jsig_pkg::ST_EMIT: begin
          op_q    <= op_q + jsig_pkg::RowAw'(1);
          if (op_last) begin
            next_job_q <= next_job_q + jsig_pkg::JobW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (state_q == jsig_pkg::ST_TQ) begin
      dur_q <= cfg_i.dur_min + fold_i.quotient;
    end
    if (state_q == jsig_pkg::ST_MQ) begin
      k_q <= op_q + fold_i.quotient[jsig_pkg::RowAw-1:0];
    end
    if (accept && exh_now) begin
      job_o_q    <= '0;
      op_o_q     <= '0;
      dur_o_q    <= '0;
      mach_o_q   <= '0;
      last_op_q  <= 1'b0;
      last_job_q <= 1'b0;
      exh_q      <= 1'b1;
    end else if (state_q == jsig_pkg::ST_EMIT) begin
      job_o_q    <= next_job_q[6:0];
      op_o_q     <= 5'(op_q);
      dur_o_q    <= dur_q;
      mach_o_q   <= 5'(rd_k_q);
      last_op_q  <= op_last;
      last_job_q <= (next_job_q == (n_eff - jsig_pkg::JobW'(1)));
      exh_q      <= 1'b0;
    end
  end

  assign result_valid_o = valid_q;
  assign job_index_o    = job_o_q;
  assign op_index_o     = op_o_q;
  assign duration_o     = dur_o_q;
  assign machine_o      = mach_o_q;
  assign last_op_o      = last_op_q;
  assign last_job_o     = last_job_q;
  assign exhausted_o    = exh_q;

`ifndef SYNTHESIS
  a_swap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsig_pkg::ST_RD) |->
      (k_q >= op_q) && (jsig_pkg::McntW'(k_q) < m_eff))
    else $error("swap index outside the unshuffled part of the row");

  a_stream_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsig_pkg::ST_TQ) |-> (time_q != jsig_pkg::LcgMod) &&
      (mach_q != jsig_pkg::LcgMod))
    else $error("stream not reduced below the modulus");

  a_op_word_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !exh_q) |-> $past(state_q == jsig_pkg::ST_EMIT))
    else $error("operation word without an emit step");

  a_exh_word_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && exh_q) |-> $past(start_i && !restart_i && !busy_o))
    else $error("exhausted word without a request");

  a_job_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsig_pkg::ST_EMIT && op_last) |=> (state_q == jsig_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after the last operation");
`endif

endmodule

@@ src/job_shop_instance_generator_top.sv @@
// ----------------------------------------------------------------------------
// job_shop_instance_generator_top
// Job-shop instance generator: one job per request, one word per operation,
// two minimal-standard streams and a shuffled machine row.
//
//   channel   signals                                    direction
//   request   start_i, busy_o, restart_i                 in, busy_o out
//   result    result_valid_o, job_index_o .. exhausted_o out, one-cycle strobe
//   config    cfg_we_i, cfg_idx_i, cfg_data_i            in, write only
//
// a job of m operations first lays down the identity row, then runs each
// operation through the TM, TF, MF, TQ, MQ, RD and EMIT states on the shared multiplier and fold unit
// an exhausted request answers in the next cycle with busy low
// busy is high for the whole job; results leave on a strobe and cannot stall
// reset loads the default registers and streams and clears the job counter
// ----------------------------------------------------------------------------
module job_shop_instance_generator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jsig_pkg::CfgIw-1:0]    cfg_idx_i,
  input  logic [jsig_pkg::SeedW-1:0]    cfg_data_i,
  input  logic                          start_i,
  input  logic                          restart_i,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output logic [6:0]                    job_index_o,
  output logic [4:0]                    op_index_o,
  output logic [jsig_pkg::DurW-1:0]     duration_o,
  output logic [4:0]                    machine_o,
  output logic                          last_op_o,
  output logic                          last_job_o,
  output logic                          exhausted_o
);

  jsig_pkg::cfg_t     cfg_q;
  jsig_pkg::mul_req_t mul_req;
  jsig_pkg::fold_t    fold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dur_seed:  jsig_pkg::TimeSeedRst,
                 mach_seed: jsig_pkg::MachSeedRst,
                 job_cnt:   jsig_pkg::JobCntRst,
                 mach_cnt:  jsig_pkg::MachCntRst,
                 dur_min:   jsig_pkg::DurMinRst,
                 dur_max:   jsig_pkg::DurMaxRst};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jsig_pkg::CFG_TIME_SEED: cfg_q.dur_seed  <= cfg_data_i;
        jsig_pkg::CFG_MACH_SEED: cfg_q.mach_seed <= cfg_data_i;
        jsig_pkg::CFG_JOB_CNT:   cfg_q.job_cnt   <= cfg_data_i[jsig_pkg::JobW-1:0];
        jsig_pkg::CFG_MACH_CNT:  cfg_q.mach_cnt  <= cfg_data_i[jsig_pkg::McntW-1:0];
        jsig_pkg::CFG_DUR_MIN:   cfg_q.dur_min   <= cfg_data_i[jsig_pkg::DurW-1:0];
        jsig_pkg::CFG_DUR_MAX:   cfg_q.dur_max   <= cfg_data_i[jsig_pkg::DurW-1:0];
        default: begin
        end
      endcase
    end
  end

  jsig_arith u_arith (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .fold_o (fold)
  );

  jsig_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .start_i        (start_i),
    .restart_i      (restart_i),
    .busy_o         (busy_o),
    .mul_req_o      (mul_req),
    .fold_i         (fold),
    .result_valid_o (result_valid_o),
    .job_index_o    (job_index_o),
    .op_index_o     (op_index_o),
    .duration_o     (duration_o),
    .machine_o      (machine_o),
    .last_op_o      (last_op_o),
    .last_job_o     (last_job_o),
    .exhausted_o    (exhausted_o)
  );

endmodule
